/* hdl/rs485_frame_checksum_checker_assert.svh */
// Assertion macros used by the checker file.
`ifndef RS485_FRAME_CHECKSUM_CHECKER_ASSERT_SVH
`define RS485_FRAME_CHECKSUM_CHECKER_ASSERT_SVH

// Check a property outside of reset.
`define RFCC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every edge, reset included.
`define RFCC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hdl/rfcc_pkg.sv */
`timescale 1ns / 1ps
package rfcc_pkg;

   localparam int BYTE_W              = 8;
   localparam int LEN_W               = 9;
   localparam int HEADER_BYTES        = 4;
   localparam int MAX_FRAME_BYTES_DEF = 511;
   localparam int LEN_FIELD_MAX       = 511;
   localparam int RSP_TDATA_W         = 48;

   typedef enum logic [1:0] {
      STATUS_VALID    = 2'd0,
      STATUS_MISMATCH = 2'd1,
      STATUS_SHORT    = 2'd2
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_length;
      logic [BYTE_W-1:0] command;
      logic [BYTE_W-1:0] sub_id;
      logic [BYTE_W-1:0] device_id;
      logic [LEN_W-1:0]  frame_length;
      logic              add_match;
      logic              xor_match;
      status_type        status;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

endpackage

/* hdl/rfcc_accum.sv */
`timescale 1ns / 1ps
module rfcc_accum #(
   parameter int MAX_FRAME_BYTES = rfcc_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_accept,
   input  logic [rfcc_pkg::BYTE_W-1:0] rx_byte,
   input  logic                        last_byte,
   output logic                        result_valid,
   output rfcc_pkg::result_type        result
);

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int EXT_W = (CNT_W + 1 > rfcc_pkg::LEN_W + 1) ? CNT_W + 1 : rfcc_pkg::LEN_W + 1;

   logic [rfcc_pkg::BYTE_W-1:0] xor_ff, xor_in;
   logic [rfcc_pkg::BYTE_W-1:0] add_ff, add_in;
   logic [rfcc_pkg::BYTE_W-1:0] prev_ff, prev_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [rfcc_pkg::BYTE_W-1:0] header_ff [rfcc_pkg::HEADER_BYTES];
   logic [rfcc_pkg::BYTE_W-1:0] header_in [rfcc_pkg::HEADER_BYTES];
   logic [rfcc_pkg::BYTE_W-1:0] header_now [rfcc_pkg::HEADER_BYTES];
   logic [EXT_W-1:0]            len_ext;
   logic                        xm;
   logic                        am;

   always_comb begin
      // byte at header position lands in the result of the same word
      for (int i = 0; i < rfcc_pkg::HEADER_BYTES; i++) begin
         header_now[i] = (count_ff == CNT_W'(i + 1)) ? rx_byte : header_ff[i];
      end

      len_ext = EXT_W'(count_ff) + EXT_W'(1);
      if (len_ext > EXT_W'(MAX_FRAME_BYTES)) begin
         len_ext = EXT_W'(MAX_FRAME_BYTES);
      end
      if (len_ext > EXT_W'(rfcc_pkg::LEN_FIELD_MAX)) begin
         len_ext = EXT_W'(rfcc_pkg::LEN_FIELD_MAX);
      end

      // XOR byte is the previous word; XOR of everything before it matches
      // exactly when the running XOR with it folded in is zero
      xm = (count_ff != '0) && ((xor_ff ^ prev_ff) == prev_ff);
      am = (count_ff != '0) && (add_ff == rx_byte);

      result_valid        = in_accept && last_byte;
      result.xor_match    = xm;
      result.add_match    = am;
      result.frame_length = len_ext[rfcc_pkg::LEN_W-1:0];
      result.device_id    = header_now[0];
      result.sub_id       = header_now[1];
      result.command      = header_now[2];
      result.data_length  = header_now[3];
      if (count_ff == '0) begin
         result.status = rfcc_pkg::STATUS_SHORT;
      end else if (xm && am) begin
         result.status = rfcc_pkg::STATUS_VALID;
      end else begin
         result.status = rfcc_pkg::STATUS_MISMATCH;
      end

      xor_in   = xor_ff;
      add_in   = add_ff;
      prev_in  = prev_ff;
      count_in = count_ff;
      for (int i = 0; i < rfcc_pkg::HEADER_BYTES; i++) begin
         header_in[i] = header_ff[i];
      end
      if (in_accept) begin
         if (last_byte) begin
            // clear for the next frame
            xor_in   = '0;
            add_in   = '0;
            prev_in  = '0;
            count_in = '0;
            for (int i = 0; i < rfcc_pkg::HEADER_BYTES; i++) begin
               header_in[i] = '0;
            end
         end else begin
            xor_in  = xor_ff ^ rx_byte;
            add_in  = add_ff + rx_byte;
            prev_in = rx_byte;
            if (count_ff != CNT_W'(MAX_FRAME_BYTES)) begin
               count_in = count_ff + CNT_W'(1);
            end
            for (int i = 0; i < rfcc_pkg::HEADER_BYTES; i++) begin
               header_in[i] = header_now[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_ff   <= '0;
         add_ff   <= '0;
         prev_ff  <= '0;
         count_ff <= '0;
         for (int i = 0; i < rfcc_pkg::HEADER_BYTES; i++) begin
            header_ff[i] <= '0;
         end
      end else begin
         xor_ff   <= xor_in;
         add_ff   <= add_in;
         prev_ff  <= prev_in;
         count_ff <= count_in;
         for (int i = 0; i < rfcc_pkg::HEADER_BYTES; i++) begin
            header_ff[i] <= header_in[i];
         end
      end
   end

endmodule

/* hdl/rfcc_out_buf.sv */
`timescale 1ns / 1ps
module rfcc_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rfcc_pkg::result_type push_data,
   output logic                 push_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rfcc_pkg::result_type out_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   rfcc_pkg::result_type main_data_ff, main_data_in;
   rfcc_pkg::result_type skid_data_ff, skid_data_in;
   logic                 pop;

   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_data_ff;
   assign pop        = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // advance the held word; no push can arrive while it waits
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_data_in  = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

/* hdl/rs485_frame_checksum_checker.sv */
`timescale 1ns / 1ps
// Channel  Direction  tdata (low bit up)                           tlast
// req      in         rx_byte[7:0]                                 last_byte
// rsp      out        status[1:0] xor_match add_match              -
//                     frame_length[8:0] device_id sub_id command
//                     data_length, zero pad to 48 bits
//
// One byte is taken every cycle while req_tready is high; the running XOR, sum and header capture
// update in a single pass on the accepted word.
// The result of a frame is registered in the output buffer before it appears on rsp.
// A two-word output buffer drops req_tready only when both words wait.
// Reset clears all frame state and the output buffer at once.
module rs485_frame_checksum_checker #(
   parameter int MAX_FRAME_BYTES = rfcc_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rfcc_pkg::BYTE_W-1:0]      req_tdata,  // rx_byte
   input  logic                             req_tlast,  // last_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rfcc_pkg::RSP_TDATA_W-1:0] rsp_tdata   // status xor_match add_match
                                                        // frame_length device_id sub_id
                                                        // command data_length, zero pad
);

   logic                 in_accept;
   logic                 result_valid;
   rfcc_pkg::result_type result;
   rfcc_pkg::result_type rsp_result;

   assign in_accept = req_tvalid && req_tready;

   rfcc_accum #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .in_accept    (in_accept),
      .rx_byte      (req_tdata),
      .last_byte    (req_tlast),
      .result_valid (result_valid),
      .result       (result)
   );

   rfcc_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (result_valid),
      .push_data  (result),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_result)
   );

   assign rsp_tdata = {{(rfcc_pkg::RSP_TDATA_W - rfcc_pkg::RESULT_W){1'b0}}, rsp_result};

endmodule

/* hdl/rfcc_checker.sv */
`timescale 1ns / 1ps
`include "rs485_frame_checksum_checker_assert.svh"
module rfcc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rfcc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   `RFCC_ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_tvalid, "result valid right after reset")

   `RFCC_ASSERT(a_rsp_hold,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata),
      "stalled result changed")

   `RFCC_ASSERT(a_valid_both_match,
      rsp_tvalid && rsp_tdata[1:0] == rfcc_pkg::STATUS_VALID |-> rsp_tdata[2] && rsp_tdata[3],
      "valid status without both matches")

   `RFCC_ASSERT(a_short_frame,
      rsp_tvalid && rsp_tdata[1:0] == rfcc_pkg::STATUS_SHORT
         |-> rsp_tdata[12:4] == 9'd1 && !rsp_tdata[2] && !rsp_tdata[3],
      "short frame result malformed")

   `RFCC_ASSERT(a_mismatch_frame,
      rsp_tvalid && rsp_tdata[1:0] == rfcc_pkg::STATUS_MISMATCH
         |-> !(rsp_tdata[2] && rsp_tdata[3]) && rsp_tdata[12:4] > 9'd1,
      "mismatch result malformed")

endmodule

bind rs485_frame_checksum_checker rfcc_checker u_rfcc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/sv/frame_report_monitor.sv */
`timescale 1ns / 1ps
module frame_report_monitor
   import rfcc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [BYTE_W-1:0]      req_tdata,
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                     error_count,
   output int                     reports_pending
);

   logic [BYTE_W-1:0] xor_acc;
   logic [BYTE_W-1:0] sum_acc;
   logic [BYTE_W-1:0] prev_byte;
   int unsigned       bytes_seen;
   logic [BYTE_W-1:0] header_bytes [HEADER_BYTES];
   result_type        frame_reports [$];

   task automatic clear_frame_state();
      xor_acc    = '0;
      sum_acc    = '0;
      prev_byte  = '0;
      bytes_seen = 0;
      foreach (header_bytes[i]) header_bytes[i] = '0;
   endtask

   // Fold one accepted word into the running frame; on the last word queue its report.
   task automatic fold_frame_byte(input logic [BYTE_W-1:0] b, input logic last);
      int unsigned       pos;
      int unsigned       n;
      logic [BYTE_W-1:0] xor_before;
      result_type        r;
      pos = bytes_seen;
      if (pos >= 1 && pos <= HEADER_BYTES) header_bytes[pos-1] = b;
      if (!last) begin
         xor_acc   = xor_acc ^ b;
         sum_acc   = sum_acc + b;
         prev_byte = b;
         if (bytes_seen < MAX_FRAME_BYTES) bytes_seen++;
      end else begin
         n = pos + 1;
         if (n > MAX_FRAME_BYTES) n = MAX_FRAME_BYTES;
         if (n > LEN_FIELD_MAX) n = LEN_FIELD_MAX;
         r = '0;
         if (pos == 0) begin
            r.status    = STATUS_SHORT;
            r.xor_match = 1'b0;
            r.add_match = 1'b0;
         end else begin
            // the word before the last one is the XOR byte; take it back out
            xor_before  = xor_acc ^ prev_byte;
            r.xor_match = (xor_before == prev_byte);
            r.add_match = (sum_acc == b);
            r.status    = (r.xor_match && r.add_match) ? STATUS_VALID : STATUS_MISMATCH;
         end
         r.frame_length = n[LEN_W-1:0];
         r.device_id    = header_bytes[0];
         r.sub_id       = header_bytes[1];
         r.command      = header_bytes[2];
         r.data_length  = header_bytes[3];
         frame_reports.push_back(r);
         clear_frame_state();
      end
   endtask

   task automatic check_field(input string name, input logic [LEN_W-1:0] want,
                              input logic [LEN_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   task automatic compare_report(input logic [RSP_TDATA_W-1:0] word);
      result_type want;
      result_type got;
      got = result_type'(word[RESULT_W-1:0]);
      if (frame_reports.size() == 0) begin
         $error("result word %h with no frame report waiting", word);
         error_count++;
      end else begin
         want = frame_reports.pop_front();
         check_field("status", LEN_W'(want.status), LEN_W'(got.status));
         check_field("xor_match", LEN_W'(want.xor_match), LEN_W'(got.xor_match));
         check_field("add_match", LEN_W'(want.add_match), LEN_W'(got.add_match));
         check_field("frame_length", want.frame_length, got.frame_length);
         check_field("device_id", LEN_W'(want.device_id), LEN_W'(got.device_id));
         check_field("sub_id", LEN_W'(want.sub_id), LEN_W'(got.sub_id));
         check_field("command", LEN_W'(want.command), LEN_W'(got.command));
         check_field("data_length", LEN_W'(want.data_length), LEN_W'(got.data_length));
         check_field("pad", '0, LEN_W'(word[RSP_TDATA_W-1:RESULT_W]));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_frame_state();
         frame_reports.delete();
         error_count = 0;
      end else begin
         if (req_tvalid && req_tready) fold_frame_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) compare_report(rsp_tdata);
      end
      reports_pending = frame_reports.size();
   end

endmodule

/* tb/sv/rs485_frame_checksum_checker_test.sv */
`timescale 1ns / 1ps
module rs485_frame_checksum_checker_test;
   import rfcc_pkg::*;

   localparam int MAX_BYTES  = MAX_FRAME_BYTES_DEF;
   localparam int IDLE_PCT   = 38;
   localparam int HOLD_LEN   = 200;
   localparam int BYTE_GOAL  = 1500;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int                     mismatches;
   int                     reports_pending;

   logic                   steady        = 1'b0;
   logic                   stall_request = 1'b0;
   logic                   stall_done    = 1'b0;
   int                     hold_left     = 0;

   logic [BYTE_W-1:0]      frame_bytes [$];
   int unsigned            bytes_sent  = 0;
   int unsigned            frames_sent = 0;

   rs485_frame_checksum_checker #(.MAX_FRAME_BYTES(MAX_BYTES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   frame_report_monitor #(.MAX_FRAME_BYTES(MAX_BYTES)) monitor (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .error_count     (mismatches),
      .reports_pending (reports_pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver: random stalls, one long hold on request, none while steady.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (stall_request && !stall_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_LEN;
         stall_done <= 1'b1;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      frames_sent++;
   endtask

   task automatic build_frame(input logic [BYTE_W-1:0] start, dev, sub, cmd, len,
                              input int unsigned data_count);
      logic [BYTE_W-1:0] x;
      logic [BYTE_W-1:0] s;
      frame_bytes = {start, dev, sub, cmd, len};
      repeat (data_count) frame_bytes.push_back(BYTE_W'($urandom));
      x = '0;
      s = '0;
      foreach (frame_bytes[i]) x = x ^ frame_bytes[i];
      frame_bytes.push_back(x);
      foreach (frame_bytes[i]) s = s + frame_bytes[i];
      frame_bytes.push_back(s);
   endtask

   task automatic build_random_frame(input int unsigned data_count);
      logic [BYTE_W-1:0] len;
      len = BYTE_W'(data_count);
      build_frame(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                  BYTE_W'($urandom), len, data_count);
   endtask

   task automatic wait_reports_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (reports_pending != 0);
      @(posedge clock);
   endtask

   initial begin
      int unsigned frame_idx;
      int unsigned pick;
      int unsigned n;
      int unsigned p;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one-byte frames, two-byte frames with matching and failing checks, then a frame with no data
      frame_bytes = {8'h00};
      send_frame();
      frame_bytes = {8'hff};
      send_frame();
      frame_bytes = {8'h00, 8'h00};
      send_frame();
      frame_bytes = {8'hff, 8'h12};
      send_frame();
      build_frame(8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 0);
      send_frame();
      // bad ADD byte only
      build_frame(8'haa, 8'h00, 8'hff, 8'h5a, 8'h01, 1);
      frame_bytes[$] = frame_bytes[$] ^ 8'h01;
      send_frame();
      // bad XOR byte, ADD byte adjusted so it still matches
      build_frame(8'h55, 8'h01, 8'h80, 8'h7f, 8'h00, 0);
      frame_bytes[$-1] = frame_bytes[$-1] ^ 8'h80;
      frame_bytes[$]   = frame_bytes[$] + 8'h80;
      send_frame();

      frame_idx = 0;
      while (bytes_sent < BYTE_GOAL) begin
         steady <= (frame_idx >= 30 && frame_idx < 45);
         if (frame_idx == 10) begin
            // frame near or over the maximum length: length field saturates, checksums keep running
            build_random_frame($urandom_range(503, 523));
            send_frame();
         end else if (frame_idx == 25) begin
            // fill the output buffer behind a long receiver hold
            stall_request <= 1'b1;
            repeat (12) begin
               send_byte(BYTE_W'($urandom), 1'b1);
               frames_sent++;
            end
            stall_request <= 1'b0;
         end else if (frame_idx == 40) begin
            build_random_frame(255);
            send_frame();
         end else if (frame_idx == 50) begin
            wait_reports_drained();
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               build_random_frame($urandom_range(0, 8));
            end else if (pick < 78) begin
               build_random_frame($urandom_range(0, 8));
               case ($urandom_range(0, 3))
                  0: begin
                     p = $urandom_range(0, frame_bytes.size() - 1);
                     frame_bytes[p] = frame_bytes[p] ^ (8'h01 << $urandom_range(0, 7));
                  end
                  1: frame_bytes.pop_back();
                  2: frame_bytes.push_back(BYTE_W'($urandom));
                  default: frame_bytes[4] = BYTE_W'($urandom);
               endcase
            end else if (pick < 92) begin
               frame_bytes.delete();
               n = $urandom_range(1, 12);
               repeat (n) frame_bytes.push_back(BYTE_W'($urandom));
            end else begin
               frame_bytes.delete();
               n = $urandom_range(1, 2);
               repeat (n) frame_bytes.push_back(BYTE_W'($urandom));
            end
            send_frame();
         end
         frame_idx++;
      end

      wait_reports_drained();
      repeat (10) @(posedge clock);

      $display("Sent %0d frames in %0d bytes: valid, corrupted, noise, one-byte and",
               frames_sent, bytes_sent);
      $display("over-length frames, under random stalls, a long output hold and a drain.");
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
